// File: src/pm_sensor_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef PM_SENSOR_FRAME_RECEIVER_ASSERT_SVH
`define PM_SENSOR_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define PMSFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define PMSFR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/pmsfr_pkg.sv
// Types and constants for the particulate sensor frame receiver.
package pmsfr_pkg;

	localparam int STORE_DEPTH_DEF = 40;

	// The check sweeps store indices 0 to 32, so that a reading at offset 31
	// can still pick up its low byte.
	localparam int          SWEEP_W    = 6;
	localparam logic [5:0]  SWEEP_LAST = 6'd32;
	localparam logic [5:0]  SUM_LEN    = 6'd30;
	localparam logic [5:0]  CHK_HI_IDX = 6'd30;
	localparam logic [5:0]  CHK_LO_IDX = 6'd31;
	localparam logic [5:0]  START_ONE_IDX = 6'd0;
	localparam logic [5:0]  START_TWO_IDX = 6'd1;

	localparam logic [7:0]  START_ONE_RST  = 8'h42;
	localparam logic [7:0]  START_TWO_RST  = 8'h4D;
	localparam logic [4:0]  PM1_OFF_RST    = 5'd4;
	localparam logic [4:0]  PM25_OFF_RST   = 5'd6;
	localparam logic [4:0]  PM10_OFF_RST   = 5'd8;
	localparam logic [15:0] IDLE_LIMIT_RST = 16'd200;

	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_START_ONE  = 3'd0,
		REG_START_TWO  = 3'd1,
		REG_PM1_OFF    = 3'd2,
		REG_PM25_OFF   = 3'd3,
		REG_PM10_OFF   = 3'd4,
		REG_IDLE_LIMIT = 3'd5
	} reg_idx_t;

	typedef enum logic {
		REQ_BYTE = 1'b0,
		REQ_TICK = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        frame_ok;
		logic [15:0] pm1_value;
		logic [15:0] pm25_value;
		logic [15:0] pm10_value;
	} out_item_t;

endpackage

// File: src/pm_sensor_frame_receiver.sv
// Particulate sensor frame receiver: byte store, idle timer and frame check.
// A byte transfer or a tick that does not time out is absorbed and gives no result.
// A tick that reaches the idle limit starts a check: the store is swept through its
// single read port, the last read drains, then the result is decided and registered.
// Throughput: one item per cycle between checks; the input is held for the whole check,
// and longer while the previous result sits stalled.
// Reset clears control state, marks every store entry unwritten and restores the defaults.
`include "pm_sensor_frame_receiver_assert.svh"

module pm_sensor_frame_receiver
	import pmsfr_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_item,

	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_item,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [AW-1:0] PTR_LAST = AW'(STORE_DEPTH - 1);
	localparam logic [SWEEP_W:0] DEPTH_W = (SWEEP_W + 1)'(STORE_DEPTH);

	// ------------------------------------------------------------------
	// Configuration registers. Writes land in the access phase; the port
	// never waits. Writes to addresses beyond the register list are dropped.
	// ------------------------------------------------------------------
	logic [7:0]  start_one_q;
	logic [7:0]  start_two_q;
	logic [4:0]  pm1_off_q;
	logic [4:0]  pm25_off_q;
	logic [4:0]  pm10_off_q;
	logic [15:0] idle_limit_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_one_q  <= START_ONE_RST;
			start_two_q  <= START_TWO_RST;
			pm1_off_q    <= PM1_OFF_RST;
			pm25_off_q   <= PM25_OFF_RST;
			pm10_off_q   <= PM10_OFF_RST;
			idle_limit_q <= IDLE_LIMIT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_START_ONE:  start_one_q  <= pwdata[7:0];
				REG_START_TWO:  start_two_q  <= pwdata[7:0];
				REG_PM1_OFF:    pm1_off_q    <= pwdata[4:0];
				REG_PM25_OFF:   pm25_off_q   <= pwdata[4:0];
				REG_PM10_OFF:   pm10_off_q   <= pwdata[4:0];
				REG_IDLE_LIMIT: idle_limit_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_START_ONE:  prdata = {24'd0, start_one_q};
			REG_START_TWO:  prdata = {24'd0, start_two_q};
			REG_PM1_OFF:    prdata = {27'd0, pm1_off_q};
			REG_PM25_OFF:   prdata = {27'd0, pm25_off_q};
			REG_PM10_OFF:   prdata = {27'd0, pm10_off_q};
			REG_IDLE_LIMIT: prdata = {16'd0, idle_limit_q};
			default:        prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input side. Bytes go straight into the store; ticks run the idle
	// timer. The input is held off for the whole check, so store writes
	// and the check's reads never meet on the same entry.
	// ------------------------------------------------------------------
	state_t             state_q;
	state_t             state_nxt;
	logic               in_xfer;
	logic               byte_wr;
	logic               tick_armed;
	logic               check_go;
	logic [AW-1:0]      wptr_q;
	logic [15:0]        idle_cnt_q;
	logic [15:0]        idle_cnt_inc;
	logic               armed_q;

	assign in_xfer      = in_valid && !in_stall;
	assign byte_wr      = in_xfer && (req_t'(in_item.req_type) == REQ_BYTE);
	assign tick_armed   = in_xfer && (req_t'(in_item.req_type) == REQ_TICK) && armed_q;
	assign idle_cnt_inc = (idle_cnt_q == 16'hFFFF) ? idle_cnt_q : idle_cnt_q + 16'd1;
	assign check_go     = tick_armed && (idle_cnt_inc >= idle_limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q     <= '0;
			idle_cnt_q <= '0;
			armed_q    <= 1'b0;
		end else if (byte_wr) begin
			// The pointer parks on the last slot, so later bytes overwrite it.
			wptr_q     <= (wptr_q == PTR_LAST) ? PTR_LAST : wptr_q + AW'(1);
			idle_cnt_q <= '0;
			armed_q    <= 1'b1;
		end else if (check_go) begin
			wptr_q     <= '0;
			idle_cnt_q <= '0;
			armed_q    <= 1'b0;
		end else if (tick_armed) begin
			idle_cnt_q <= idle_cnt_inc;
		end
	end

	// ------------------------------------------------------------------
	// Byte store: one write port for arriving bytes, one registered read
	// port for the check. Entries never written since reset read as zero
	// through their valid bit.
	// ------------------------------------------------------------------
	logic [7:0]             mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] written_q;
	logic [SWEEP_W-1:0]     sweep_q;
	logic [AW-1:0]          rd_addr;
	logic                   rd_in_range;
	logic                   rd_issue;
	logic [7:0]             rd_data_s1;
	logic                   rd_written_s1;
	logic                   rd_en_s1;
	logic [SWEEP_W-1:0]     rd_idx_s1;

	assign rd_in_range = ({1'b0, sweep_q} < DEPTH_W);
	assign rd_addr     = sweep_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (byte_wr) begin
			mem_q[wptr_q] <= in_item.rx_byte;
		end
		if (rd_issue && rd_in_range) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (byte_wr) begin
			written_q[wptr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1      <= 1'b0;
			rd_written_s1 <= 1'b0;
			rd_idx_s1     <= '0;
		end else begin
			rd_en_s1      <= rd_issue;
			rd_written_s1 <= rd_in_range && written_q[rd_addr];
			rd_idx_s1     <= sweep_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (check_go) begin
			sweep_q <= '0;
		end else if (rd_issue) begin
			sweep_q <= sweep_q + SWEEP_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Check datapath: each byte that comes back is summed if it lies in
	// the summed range and captured where its index matches a start byte,
	// a checksum byte or one byte of a reading.
	// ------------------------------------------------------------------
	logic [7:0]         rd_byte;
	logic [15:0]        sum_q;
	logic [7:0]         b0_q;
	logic [7:0]         b1_q;
	logic [7:0]         chk_hi_q;
	logic [7:0]         chk_lo_q;
	logic [7:0]         pm_hi_q [3];
	logic [7:0]         pm_lo_q [3];
	logic [SWEEP_W-1:0] pm_off [3];

	assign rd_byte   = rd_written_s1 ? rd_data_s1 : 8'd0;
	assign pm_off[0] = SWEEP_W'(pm1_off_q);
	assign pm_off[1] = SWEEP_W'(pm25_off_q);
	assign pm_off[2] = SWEEP_W'(pm10_off_q);

	always_ff @(posedge clk) begin
		if (check_go) begin
			sum_q <= '0;
		end else if (rd_en_s1) begin
			if (rd_idx_s1 < SUM_LEN) begin
				sum_q <= sum_q + {8'd0, rd_byte};
			end
			if (rd_idx_s1 == START_ONE_IDX) begin
				b0_q <= rd_byte;
			end
			if (rd_idx_s1 == START_TWO_IDX) begin
				b1_q <= rd_byte;
			end
			if (rd_idx_s1 == CHK_HI_IDX) begin
				chk_hi_q <= rd_byte;
			end
			if (rd_idx_s1 == CHK_LO_IDX) begin
				chk_lo_q <= rd_byte;
			end
			for (int i = 0; i < 3; i++) begin
				if (rd_idx_s1 == pm_off[i]) begin
					pm_hi_q[i] <= rd_byte;
				end
				if (rd_idx_s1 == pm_off[i] + SWEEP_W'(1)) begin
					pm_lo_q[i] <= rd_byte;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: sweep the store, drain the last read, then decide and
	// load the result register once it is free.
	// ------------------------------------------------------------------
	logic out_free;
	logic emit;

	assign out_free = !out_valid || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (check_go) state_nxt = ST_READ;
			ST_READ:   if (sweep_q == SWEEP_LAST) state_nxt = ST_FINISH;
			ST_FINISH: state_nxt = ST_EMIT;
			ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_issue = 1'b0;
		emit     = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_READ:   rd_issue = 1'b1;
			ST_FINISH: ;
			ST_EMIT:   emit = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Result register and latched readings. A failed check repeats the
	// readings of the last good frame.
	// ------------------------------------------------------------------
	logic        frame_good;
	logic [15:0] pm1_lat_q;
	logic [15:0] pm25_lat_q;
	logic [15:0] pm10_lat_q;
	logic [15:0] pm1_new;
	logic [15:0] pm25_new;
	logic [15:0] pm10_new;

	assign frame_good = (b0_q == start_one_q) && (b1_q == start_two_q)
		&& (sum_q == {chk_hi_q, chk_lo_q});
	assign pm1_new  = frame_good ? {pm_hi_q[0], pm_lo_q[0]} : pm1_lat_q;
	assign pm25_new = frame_good ? {pm_hi_q[1], pm_lo_q[1]} : pm25_lat_q;
	assign pm10_new = frame_good ? {pm_hi_q[2], pm_lo_q[2]} : pm10_lat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm1_lat_q  <= '0;
			pm25_lat_q <= '0;
			pm10_lat_q <= '0;
		end else if (emit) begin
			pm1_lat_q  <= pm1_new;
			pm25_lat_q <= pm25_new;
			pm10_lat_q <= pm10_new;
		end
	end

	out_item_t out_item_q;
	logic      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q.frame_ok   <= frame_good;
			out_item_q.pm1_value  <= pm1_new;
			out_item_q.pm25_value <= pm25_new;
			out_item_q.pm10_value <= pm10_new;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	logic sweep_end;

	assign sweep_end = (state_q == ST_READ) && (sweep_q == SWEEP_LAST);

	`PMSFR_ASSERT_IMP(a_wptr_range, 1'b1, wptr_q <= PTR_LAST, "write pointer past last slot")
	`PMSFR_ASSERT_IMP(a_disarmed_clear, !armed_q, idle_cnt_q == 16'd0, "count while disarmed")
	`PMSFR_ASSERT_NXT(a_sweep_end, sweep_end, (state_q == ST_FINISH) && !rd_issue, "sweep overran")
	`PMSFR_ASSERT_IMP(a_result_source, $rose(out_valid_q), $past(state_q) == ST_EMIT, "stray result")

endmodule

// File: verif/pm_sensor_frame_receiver_test.sv
// Self-checking testbench for the particulate sensor frame receiver.
`timescale 1ns / 1ps

module pm_sensor_frame_receiver_test;
	import pmsfr_pkg::*;

	// Cycles allowed after the last verdict before the block counts as idle.
	// It is sized to cover any check that is still in flight.
	localparam int LATENCY_SLACK = 40;
	localparam int MAX_BURST     = 45;
	localparam int ITEM_TARGET   = 1300;

	// Register index that has no register behind it. Writes to it must be dropped.
	localparam logic [2:0] REG_SPARE = 3'(REG_IDLE_LIMIT) + 3'd1;

	localparam out_item_t VERDICT_OK_BLANK  = '{1'b1, 16'h0000, 16'h0000, 16'h0000};
	localparam out_item_t VERDICT_BAD_BLANK = '{1'b0, 16'h0000, 16'h0000, 16'h0000};

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_TICK,
		ROW_WRITE
	} row_op_t;

	// One line of the directed script. For a write, reg_sel and data give the
	// register and the bus value. For a byte or a tick, data[7:0] is the byte.
	// Where typed is set, want is the verdict read straight off the behavior.
	typedef struct {
		row_op_t     op;
		logic [2:0]  reg_sel;
		logic [31:0] data;
		bit          typed;
		out_item_t   want;
	} script_row_t;

	localparam int SCRIPT_LEN = 25;

	// The directed part starts from start bytes of zero, so a store of zeros is a
	// good frame. It walks the zero idle limit, ticks with the timer disarmed,
	// each start byte wrong in turn, a tick below the limit and a byte that re-arms
	// the timer, and a write to an address with no register.
	script_row_t script [SCRIPT_LEN] = '{
		'{ROW_WRITE, REG_START_ONE,  32'h0000_0000, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_WRITE, REG_START_TWO,  32'hFFFF_FF00, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_WRITE, REG_IDLE_LIMIT, 32'hFFFF_0000, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_00FF, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_BYTE,  REG_START_ONE,  32'h0000_0000, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_0000, 1'b1, VERDICT_OK_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_0000, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_BYTE,  REG_START_ONE,  32'h0000_00FF, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_00FF, 1'b1, VERDICT_BAD_BLANK},
		'{ROW_BYTE,  REG_START_ONE,  32'h0000_0000, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_BYTE,  REG_START_ONE,  32'h0000_00FF, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_005A, 1'b1, VERDICT_BAD_BLANK},
		'{ROW_WRITE, REG_SPARE,      32'hFFFF_FFFF, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_WRITE, REG_IDLE_LIMIT, 32'h0000_0003, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_BYTE,  REG_START_ONE,  32'h0000_00A5, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_0081, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_007E, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_BYTE,  REG_START_ONE,  32'h0000_005A, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_0001, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_0002, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_0004, 1'b1, VERDICT_BAD_BLANK},
		'{ROW_WRITE, REG_IDLE_LIMIT, 32'h0000_0001, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_BYTE,  REG_START_ONE,  32'h0000_0000, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_BYTE,  REG_START_ONE,  32'h0000_0000, 1'b0, VERDICT_BAD_BLANK},
		'{ROW_TICK,  REG_START_ONE,  32'h0000_0010, 1'b1, VERDICT_OK_BLANK}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_item;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_item;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Shadow of the block: registers, byte store, timer and latched readings.
	logic [7:0]  sb_one;
	logic [7:0]  sb_two;
	logic [4:0]  off_pm1;
	logic [4:0]  off_pm25;
	logic [4:0]  off_pm10;
	logic [15:0] idle_lim;
	logic [7:0]  store_img [STORE_DEPTH_DEF];
	logic [5:0]  wr_ptr;
	logic [15:0] idle_cnt;
	bit          armed;
	logic [15:0] pm1_held;
	logic [15:0] pm25_held;
	logic [15:0] pm10_held;

	out_item_t verdict_q [$];
	out_item_t head_verdict;
	int        errors = 0;
	int        items_done = 0;
	int        stall_left = 0;
	bit        calm = 1'b0;

	pm_sensor_frame_receiver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length for either side: mostly none, often a few cycles, now and then a
	// long one. In a calm stretch neither side idles at all.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom % 100;
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom % 10;
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void reset_shadow();
		sb_one    = START_ONE_RST;
		sb_two    = START_TWO_RST;
		off_pm1   = PM1_OFF_RST;
		off_pm25  = PM25_OFF_RST;
		off_pm10  = PM10_OFF_RST;
		idle_lim  = IDLE_LIMIT_RST;
		foreach (store_img[i])
			store_img[i] = 8'h00;
		wr_ptr    = '0;
		idle_cnt  = '0;
		armed     = 1'b0;
		pm1_held  = '0;
		pm25_held = '0;
		pm10_held = '0;
	endfunction

	function automatic logic [31:0] reg_value(logic [2:0] sel);
		case (sel)
			REG_START_ONE:  return {24'h0, sb_one};
			REG_START_TWO:  return {24'h0, sb_two};
			REG_PM1_OFF:    return {27'h0, off_pm1};
			REG_PM25_OFF:   return {27'h0, off_pm25};
			REG_PM10_OFF:   return {27'h0, off_pm10};
			REG_IDLE_LIMIT: return {16'h0, idle_lim};
			default:        return 32'h0;
		endcase
	endfunction

	function automatic void apply_reg(logic [2:0] sel, logic [31:0] v);
		case (sel)
			REG_START_ONE:  sb_one   = v[7:0];
			REG_START_TWO:  sb_two   = v[7:0];
			REG_PM1_OFF:    off_pm1  = v[4:0];
			REG_PM25_OFF:   off_pm25 = v[4:0];
			REG_PM10_OFF:   off_pm10 = v[4:0];
			REG_IDLE_LIMIT: idle_lim = v[15:0];
			default:        ;
		endcase
	endfunction

	// Entries past the end of the store read as zero.
	function automatic logic [7:0] store_at(int idx);
		return (idx >= STORE_DEPTH_DEF) ? 8'h00 : store_img[idx];
	endfunction

	function automatic logic [15:0] word_at(int idx);
		return {store_at(idx), store_at(idx + 1)};
	endfunction

	// Advances the shadow by one accepted transfer. Returns 1 and the verdict
	// when the transfer is a tick that runs the idle timer out.
	function automatic bit absorb_item(in_item_t it, output out_item_t verdict);
		logic [15:0] sum;
		bit          ok;
		verdict = '0;
		if (it.req_type == REQ_BYTE) begin
			store_img[wr_ptr] = it.rx_byte;
			if (wr_ptr < STORE_DEPTH_DEF - 1)
				wr_ptr = wr_ptr + 6'd1;
			idle_cnt = '0;
			armed    = 1'b1;
			return 1'b0;
		end
		if (!armed)
			return 1'b0;
		if (idle_cnt != 16'hFFFF)
			idle_cnt = idle_cnt + 16'd1;
		if (idle_cnt < idle_lim)
			return 1'b0;
		wr_ptr   = '0;
		idle_cnt = '0;
		armed    = 1'b0;
		sum = '0;
		for (int i = 0; i < SUM_LEN; i++)
			sum = sum + 16'(store_at(i));
		ok = store_at(START_ONE_IDX) == sb_one && store_at(START_TWO_IDX) == sb_two &&
			sum == word_at(CHK_HI_IDX);
		if (ok) begin
			pm1_held  = word_at(off_pm1);
			pm25_held = word_at(off_pm25);
			pm10_held = word_at(off_pm10);
		end
		verdict = '{ok, pm1_held, pm25_held, pm10_held};
		return 1'b1;
	endfunction

	// One APB transfer: setup cycle, then access cycle until pready.
	task automatic apb_xfer(input bit wr, input logic [2:0] sel, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {sel, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input logic [2:0] sel, input logic [31:0] v);
		logic [31:0] unused;
		apb_xfer(1'b1, sel, v, unused);
		apply_reg(sel, v);
	endtask

	// Reads every register back and compares it with the shadow copy.
	task automatic check_regs();
		logic [31:0] rd;
		for (int i = REG_START_ONE; i <= REG_IDLE_LIMIT; i++) begin
			apb_xfer(1'b0, 3'(i), 32'h0, rd);
			if (rd !== reg_value(3'(i))) begin
				$display("%0t ns: register %0d expected %0h, got %0h",
					$time, i, reg_value(3'(i)), rd);
				errors++;
			end
		end
	endtask

	// Drops valid, then waits until every verdict is back and any check that is
	// still running has had time to finish, so that registers can be rewritten.
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	// Presents one item after a random gap and holds it until the transfer.
	// The shadow is advanced at the edge where the transfer takes place.
	task automatic send_item(input req_t kind, input logic [7:0] data, input bit typed,
			input out_item_t want);
		int        gap;
		in_item_t  it;
		out_item_t verdict;
		bit        has_verdict;
		it.req_type = kind;
		it.rx_byte  = data;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		if (kind == REQ_BYTE || armed)
			items_done++;
		has_verdict = absorb_item(it, verdict);
		if (typed)
			verdict_q.push_back(want);
		else if (has_verdict)
			verdict_q.push_back(verdict);
	endtask

	// Sends a burst of bytes followed by enough ticks to run the timer out and a
	// few spare ticks that land on a disarmed timer. A well-formed burst carries
	// the configured start bytes and a matching sum; corrupt flips one bit of it.
	task automatic send_burst(input int n, input bit well_formed, input bit corrupt);
		logic [7:0]  fb [MAX_BURST];
		logic [15:0] sum;
		int          k;
		int          n_ticks;
		foreach (fb[i])
			fb[i] = pick_byte();
		if (well_formed) begin
			fb[START_ONE_IDX] = sb_one;
			fb[START_TWO_IDX] = sb_two;
			sum = '0;
			for (int i = 0; i < SUM_LEN; i++)
				sum = sum + 16'(fb[i]);
			fb[CHK_HI_IDX] = sum[15:8];
			fb[CHK_LO_IDX] = sum[7:0];
		end
		if (corrupt) begin
			k = $urandom_range(0, CHK_LO_IDX);
			fb[k] = fb[k] ^ (8'd1 << $urandom_range(0, 7));
		end
		for (int i = 0; i < n; i++)
			send_item(REQ_BYTE, fb[i], 1'b0, '0);
		n_ticks = (idle_lim == 16'd0) ? 1 : int'(idle_lim);
		n_ticks += $urandom_range(0, 2);
		repeat (n_ticks)
			send_item(REQ_TICK, pick_byte(), 1'b0, '0);
	endtask

	// A fresh register setting, leaning on the extremes of each field. The
	// unused upper bits of the bus carry random data and must be dropped.
	task automatic new_setting();
		int          r;
		logic [4:0]  off;
		logic [15:0] lim;
		logic [7:0]  sb;
		for (int i = REG_START_ONE; i <= REG_START_TWO; i++) begin
			r = $urandom % 5;
			sb = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
			cfg_write(3'(i), {24'($urandom), sb});
		end
		for (int i = REG_PM1_OFF; i <= REG_PM10_OFF; i++) begin
			r = $urandom % 10;
			case (r)
				0: off = 5'd0;
				1: off = 5'd31;
				2: off = 5'd2;
				3: off = 5'd28;
				default: off = 5'($urandom_range(0, 31));
			endcase
			cfg_write(3'(i), {27'($urandom), off});
		end
		r = $urandom % 10;
		if (r == 0)
			lim = 16'd0;
		else if (r == 1)
			lim = 16'd1;
		else if (r == 9)
			lim = 16'($urandom_range(20, 40));
		else
			lim = 16'($urandom_range(2, 6));
		cfg_write(REG_IDLE_LIMIT, {16'($urandom), lim});
		check_regs();
	endtask

	// Output side stalls at random: bursts of stall with open stretches between
	// them, none at all in a calm stretch.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	// Every verdict that leaves the block is matched against the oldest one
	// still waiting, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$display("%0t ns: verdict with none expected, got %p", $time, out_item);
				errors++;
			end else begin
				head_verdict = verdict_q.pop_front();
				if (out_item.frame_ok !== head_verdict.frame_ok) begin
					$display("%0t ns: frame_ok expected %0d, got %0d",
						$time, head_verdict.frame_ok, out_item.frame_ok);
					errors++;
				end
				if (out_item.pm1_value !== head_verdict.pm1_value) begin
					$display("%0t ns: pm1_value expected %0h, got %0h",
						$time, head_verdict.pm1_value, out_item.pm1_value);
					errors++;
				end
				if (out_item.pm25_value !== head_verdict.pm25_value) begin
					$display("%0t ns: pm25_value expected %0h, got %0h",
						$time, head_verdict.pm25_value, out_item.pm25_value);
					errors++;
				end
				if (out_item.pm10_value !== head_verdict.pm10_value) begin
					$display("%0t ns: pm10_value expected %0h, got %0h",
						$time, head_verdict.pm10_value, out_item.pm10_value);
					errors++;
				end
			end
		end
	end

	initial begin
		#100_000_000;
		$display("pm_sensor_frame_receiver: mismatch");
		$finish;
	end

	initial begin
		int r;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		reset_shadow();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The registers must come out of reset at their defaults.
		check_regs();

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			case (script[i].op)
				ROW_WRITE: begin
					wait_quiet();
					cfg_write(script[i].reg_sel, script[i].data);
					check_regs();
				end
				ROW_BYTE:
					send_item(REQ_BYTE, script[i].data[7:0], script[i].typed, script[i].want);
				default:
					send_item(REQ_TICK, script[i].data[7:0], script[i].typed, script[i].want);
			endcase
		end

		// Random part: phases of a few frames under one setting each. Most frames
		// are well formed with random content. The rest are longer bursts that can
		// pin the write pointer, corrupted frames, short bursts that leave stale
		// bytes in play, and loose mixes of bytes and ticks.
		while (items_done < ITEM_TARGET) begin
			wait_quiet();
			new_setting();
			repeat ($urandom_range(2, 5)) begin
				calm = ($urandom % 5) == 0;
				r = $urandom % 100;
				if (r < 60)
					send_burst(CHK_LO_IDX + 1, 1'b1, 1'b0);
				else if (r < 70)
					send_burst($urandom_range(CHK_LO_IDX + 2, MAX_BURST), 1'b1, 1'b0);
				else if (r < 80)
					send_burst(CHK_LO_IDX + 1, 1'b1, 1'b1);
				else if (r < 88)
					send_burst($urandom_range(1, CHK_LO_IDX), 1'($urandom), 1'b0);
				else begin
					repeat ($urandom_range(1, 30))
						send_item(req_t'($urandom % 2), pick_byte(), 1'b0, '0);
				end
			end
			calm = 1'b0;
		end

		// The largest idle limit: a frame and a few ticks must not start a check.
		// Lowering the limit then lets the next tick run the timer out.
		wait_quiet();
		cfg_write(REG_IDLE_LIMIT, 32'h0000_FFFF);
		check_regs();
		for (int i = 0; i < CHK_LO_IDX + 1; i++)
			send_item(REQ_BYTE, pick_byte(), 1'b0, '0);
		repeat (8)
			send_item(REQ_TICK, pick_byte(), 1'b0, '0);
		wait_quiet();
		cfg_write(REG_IDLE_LIMIT, 32'h0000_0004);
		check_regs();
		send_item(REQ_TICK, pick_byte(), 1'b0, '0);

		wait_quiet();
		if (errors == 0)
			$display("pm_sensor_frame_receiver: match");
		else
			$display("pm_sensor_frame_receiver: mismatch");
		$finish;
	end

endmodule
